[hdl/wwpp_pkg.sv]
// Shared types, sizes and cell codes of the Wireworld++ generation step.
`timescale 1ns / 1ps
package wwpp_pkg;

   // Grid limits.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   // Field and counter widths.
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WIDTH_W   = 11;
   localparam int HEIGHT_W  = 13;
   localparam int ROW_W     = $clog2(MAX_HEIGHT + 2);
   localparam int CELL_W    = 3;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 13;

   // Line buffer entry holds the upper and the middle line side by side.
   localparam int LINE_W = 2 * CELL_W;

   // Result queue.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef logic [CELL_W-1:0] cell_type;

   localparam cell_type CELL_EMPTY       = 3'd0;
   localparam cell_type CELL_STRONG_HEAD = 3'd1;
   localparam cell_type CELL_STRONG_TAIL = 3'd2;
   localparam cell_type CELL_STRONG_WIRE = 3'd3;
   localparam cell_type CELL_WEAK_HEAD   = 3'd4;
   localparam cell_type CELL_WEAK_TAIL   = 3'd5;
   localparam cell_type CELL_WEAK_WIRE   = 3'd6;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 8'd1;

   // Which sides of the centre cell's neighbourhood lie outside the grid.
   typedef struct packed {
      logic top_out;
      logic bottom_out;
      logic left_out;
      logic right_out;
   } bound_type;

   // Per-beat control that travels down the pipeline.
   typedef struct packed {
      logic      emit;
      logic      last;
      bound_type bounds;
   } meta_type;

   typedef struct packed {
      cell_type next_state;
      logic     last_cell;
   } rsp_entry_type;

endpackage

[hdl/wwpp_req_if.sv]
// Cell input channel with valid/ready handshake.
`timescale 1ns / 1ps
interface wwpp_req_if import wwpp_pkg::*; ();
   logic     valid;
   logic     ready;
   cell_type cell_state;
   logic     pad;

   modport source (output valid, output cell_state, output pad, input ready);
   modport sink   (input valid, input cell_state, input pad, output ready);
endinterface

[hdl/wwpp_rsp_if.sv]
// Result channel with valid/ready handshake.
`timescale 1ns / 1ps
interface wwpp_rsp_if import wwpp_pkg::*; ();
   logic     valid;
   logic     ready;
   cell_type next_state;
   logic     last_cell;

   modport source (output valid, output next_state, output last_cell, input ready);
   modport sink   (input valid, input next_state, input last_cell, output ready);
endinterface

[hdl/wwpp_csr_if.sv]
// Register write channel with valid/ready handshake.
`timescale 1ns / 1ps
interface wwpp_csr_if import wwpp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/wwpp_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module wwpp_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [DATA_W-1:0]         wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [DATA_W-1:0]         rd_data
);
   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[hdl/wwpp_rule.sv]
// Neighbour count and state transition for the centre cell of the window.
`timescale 1ns / 1ps
module wwpp_rule import wwpp_pkg::*; (
   input  cell_type  window [9],
   input  bound_type bounds,
   output cell_type next_state
);
   logic [3:0] strong_cnt;
   logic [3:0] weak_cnt;
   logic       use_cell;

   // Cells outside the grid are skipped, which counts them as empty.
   always_comb begin
      strong_cnt = 4'd0;
      weak_cnt   = 4'd0;
      use_cell   = 1'b0;
      for (int k = 0; k < 9; k++) begin
         use_cell = (k != 4);
         if ((k / 3 == 0) && bounds.top_out)    use_cell = 1'b0;
         if ((k / 3 == 2) && bounds.bottom_out) use_cell = 1'b0;
         if ((k % 3 == 0) && bounds.left_out)   use_cell = 1'b0;
         if ((k % 3 == 2) && bounds.right_out)  use_cell = 1'b0;
         if (use_cell && window[k] == CELL_STRONG_HEAD) strong_cnt = strong_cnt + 4'd1;
         if (use_cell && window[k] == CELL_WEAK_HEAD)   weak_cnt   = weak_cnt + 4'd1;
      end
   end

   always_comb begin
      unique case (window[4])
         CELL_STRONG_HEAD: next_state = CELL_STRONG_TAIL;
         CELL_STRONG_TAIL: next_state = CELL_STRONG_WIRE;
         CELL_WEAK_HEAD:   next_state = CELL_WEAK_TAIL;
         CELL_WEAK_TAIL:   next_state = CELL_WEAK_WIRE;
         CELL_STRONG_WIRE: begin
            next_state = (strong_cnt == 4'd1 || strong_cnt == 4'd2 || weak_cnt == 4'd2) ?
                         CELL_STRONG_HEAD : CELL_STRONG_WIRE;
         end
         CELL_WEAK_WIRE: begin
            next_state = (weak_cnt == 4'd1 || weak_cnt == 4'd2 || strong_cnt == 4'd1) ?
                         CELL_WEAK_HEAD : CELL_WEAK_WIRE;
         end
         default: next_state = CELL_EMPTY;
      endcase
   end
endmodule

[hdl/wireworld_pp_generation_step_top.sv]
// Top level of the Wireworld++ generation step over a raster cell stream.
`timescale 1ns / 1ps
// Path: the beat that completes a cell's neighbourhood, which is the beat one row and
//    one cell later (W+1 beats of lag), passes stage 1, stage 2 and the result queue.
// Throughput: one beat per cycle while the queue has room, set by the single line-buffer
//    RAM read and written once per beat; the four-entry queue keeps input and output apart.
// Reset: grid size returns to its maximum, position counters to zero, the window to all
//    empty and the pipeline and queue to empty. The line buffer is left as it is.
module wireworld_pp_generation_step_top import wwpp_pkg::*; (
   input logic        clock,
   input logic        reset,
   wwpp_req_if.sink   req_bus,
   wwpp_rsp_if.source rsp_bus,
   wwpp_csr_if.sink   csr_bus
);

   // ---------------------------------------------------------------------------------------
   // Configuration. Sizes are clamped into range when written, and a write to the width or
   // height register restarts the frame.
   // ---------------------------------------------------------------------------------------
   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic                csr_write;
   logic                csr_known;
   logic [WIDTH_W-1:0]  csr_width_raw;
   logic [HEIGHT_W-1:0] csr_height_raw;

   assign csr_bus.ready  = 1'b1;
   assign csr_write      = csr_bus.valid;
   assign csr_known      = (csr_bus.index == REG_GRID_WIDTH) ||
                           (csr_bus.index == REG_GRID_HEIGHT);
   assign csr_width_raw  = csr_bus.data[WIDTH_W-1:0];
   assign csr_height_raw = csr_bus.data[HEIGHT_W-1:0];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write && csr_bus.index == REG_GRID_WIDTH) begin
         priority if (csr_width_raw == '0)                       width_in = WIDTH_W'(1);
         else if (csr_width_raw > WIDTH_W'(MAX_WIDTH))           width_in = WIDTH_W'(MAX_WIDTH);
         else                                                    width_in = csr_width_raw;
      end
      if (csr_write && csr_bus.index == REG_GRID_HEIGHT) begin
         priority if (csr_height_raw == '0)                      height_in = HEIGHT_W'(1);
         else if (csr_height_raw > HEIGHT_W'(MAX_HEIGHT))        height_in = HEIGHT_W'(MAX_HEIGHT);
         else                                                    height_in = csr_height_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_W'(MAX_WIDTH);
         height_ff <= HEIGHT_W'(MAX_HEIGHT);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 0: accept a beat, classify its position in the frame and issue the line-buffer
   // read. The neighbourhood that completes with this beat is centred one row up and one
   // column to the left, or at the end of the row before last when this beat opens a row.
   // ---------------------------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             req_fire;
   logic             col_zero;
   logic             col_wrap;
   logic [ROW_W-1:0] h_ext;
   logic             row_past;
   logic             row_past2;
   cell_type         cell_masked;
   meta_type         meta0;

   logic [FIFO_CNT_W:0] credit_used;
   logic [FIFO_CNT_W-1:0] fifo_cnt_ff, fifo_cnt_in;
   logic                  s1_valid_ff, s2_valid_ff;

   // A beat is taken only when the queue has room for every result still in flight.
   assign credit_used = (FIFO_CNT_W+1)'(fifo_cnt_ff) + (FIFO_CNT_W+1)'(s1_valid_ff) +
                        (FIFO_CNT_W+1)'(s2_valid_ff);
   assign req_bus.ready = credit_used < (FIFO_CNT_W+1)'(FIFO_DEPTH);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign h_ext     = ROW_W'(height_ff);
   assign col_zero  = (col_ff == '0);
   assign col_wrap  = (WIDTH_W'(col_ff) + WIDTH_W'(1)) == width_ff;
   assign row_past  = row_ff >= h_ext;
   assign row_past2 = row_ff >= (h_ext + ROW_W'(1));

   // Pad beats and every beat past the last grid row enter as empty cells.
   assign cell_masked = (req_bus.pad || row_past) ? CELL_EMPTY : req_bus.cell_state;

   always_comb begin
      meta0.emit              = (row_ff >= ROW_W'(2)) || (row_ff == ROW_W'(1) && !col_zero);
      meta0.bounds.top_out    = col_zero ? (row_ff == ROW_W'(2)) : (row_ff == ROW_W'(1));
      meta0.bounds.bottom_out = col_zero ? row_past2 : row_past;
      meta0.bounds.left_out   = col_zero ? (width_ff == WIDTH_W'(1)) : (col_ff == COL_W'(1));
      meta0.bounds.right_out  = col_zero;
      meta0.last              = col_zero && row_past2;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (csr_write && csr_known) begin
         col_in = '0;
         row_in = '0;
      end else if (req_fire) begin
         priority if (meta0.last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end else begin
         col_in = col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 1: the line-buffer word arrives, the window shifts left by one column and the
   // word is written back with the middle line moved up and the new cell below it. With a
   // one-cell row the next read hits the entry written in the same cycle, so that word is
   // forwarded.
   // ---------------------------------------------------------------------------------------
   logic [COL_W-1:0]  s1_addr_ff;
   cell_type          s1_cell_ff;
   meta_type          s1_meta_ff;
   logic              s1_hit_ff;
   logic [LINE_W-1:0] s1_fwd_ff;
   logic [LINE_W-1:0] ram_q;
   logic [LINE_W-1:0] line_word;
   logic [LINE_W-1:0] line_wr_data;

   wwpp_ram #(
      .DATA_W (LINE_W),
      .DEPTH  (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (line_wr_data),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (ram_q)
   );

   assign line_word    = s1_hit_ff ? s1_fwd_ff : ram_q;
   assign line_wr_data = {line_word[CELL_W-1:0], s1_cell_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_addr_ff <= col_ff;
         s1_cell_ff <= cell_masked;
         s1_meta_ff <= meta0;
         s1_hit_ff  <= s1_valid_ff && (s1_addr_ff == col_ff);
         s1_fwd_ff  <= line_wr_data;
      end
   end

   // Window: index row*3+col, column 2 being the newest.
   cell_type window_ff [9];
   cell_type window_in [9];

   always_comb begin
      window_in = window_ff;
      if (s1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            window_in[k*3]   = window_ff[k*3+1];
            window_in[k*3+1] = window_ff[k*3+2];
         end
         window_in[2] = line_word[LINE_W-1:CELL_W];
         window_in[5] = line_word[CELL_W-1:0];
         window_in[8] = s1_cell_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            window_ff[k] <= CELL_EMPTY;
         end
      end else begin
         window_ff <= window_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 2: count the heads around the centre and apply the transition rule.
   // ---------------------------------------------------------------------------------------
   meta_type s2_meta_ff;
   cell_type rule_next;
   logic     fifo_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_meta_ff <= s1_meta_ff;
      end
   end

   wwpp_rule u_rule (
      .window     (window_ff),
      .bounds     (s2_meta_ff.bounds),
      .next_state (rule_next)
   );

   assign fifo_push = s2_valid_ff && s2_meta_ff.emit;

   // ---------------------------------------------------------------------------------------
   // Result queue.
   // ---------------------------------------------------------------------------------------
   rsp_entry_type         fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic                  fifo_pop;

   assign rsp_bus.valid      = (fifo_cnt_ff != '0);
   assign rsp_bus.next_state = fifo_ff[rd_ptr_ff].next_state;
   assign rsp_bus.last_cell  = fifo_ff[rd_ptr_ff].last_cell;
   assign fifo_pop           = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      fifo_cnt_in = fifo_cnt_ff;
      unique case ({fifo_push, fifo_pop})
         2'b10:   fifo_cnt_in = fifo_cnt_ff + FIFO_CNT_W'(1);
         2'b01:   fifo_cnt_in = fifo_cnt_ff - FIFO_CNT_W'(1);
         default: fifo_cnt_in = fifo_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         fifo_cnt_ff <= fifo_cnt_in;
         if (fifo_push) wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         if (fifo_pop)  rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_ff[wr_ptr_ff].next_state <= rule_next;
         fifo_ff[wr_ptr_ff].last_cell  <= s2_meta_ff.last;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------------------------

   // Results in flight plus those queued never exceed the queue.
   assert property (@(posedge clock) disable iff (reset)
      credit_used <= (FIFO_CNT_W+1)'(FIFO_DEPTH))
      else $error("result queue overcommitted");

   // A push never meets a full queue.
   assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> (fifo_cnt_ff < FIFO_CNT_W'(FIFO_DEPTH)) || fifo_pop)
      else $error("push into full result queue");

   // The beat that closes a frame returns the position to the origin.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && meta0.last) |=> (col_ff == '0 && row_ff == '0))
      else $error("frame did not restart after its last cell");

   // The column position stays inside the row.
   assert property (@(posedge clock) disable iff (reset)
      WIDTH_W'(col_ff) < width_ff)
      else $error("column position beyond row width");

endmodule
